[rtl/tkz_pkg.sv]
// Shared types and constants of the source character tokenizer.
// Holds scanner modes, token kind codes, character codes and the keyword table.
// No dependencies.
package tkz_pkg;

  typedef enum logic [2:0] {
    M_START,
    M_IDENT,
    M_INT,
    M_INTDOT,
    M_REAL,
    M_STRING,
    M_COMMENT,
    M_OPWAIT
  } scan_mode_t;

  localparam logic [4:0] K_IDENT  = 5'd10;
  localparam logic [4:0] K_ICONST = 5'd11;
  localparam logic [4:0] K_RCONST = 5'd12;
  localparam logic [4:0] K_SCONST = 5'd13;
  localparam logic [4:0] K_PLUS   = 5'd14;
  localparam logic [4:0] K_MINUS  = 5'd15;
  localparam logic [4:0] K_MULT   = 5'd16;
  localparam logic [4:0] K_DIV    = 5'd17;
  localparam logic [4:0] K_ASSOP  = 5'd18;
  localparam logic [4:0] K_EQ     = 5'd19;
  localparam logic [4:0] K_POW    = 5'd20;
  localparam logic [4:0] K_GTHAN  = 5'd21;
  localparam logic [4:0] K_LTHAN  = 5'd22;
  localparam logic [4:0] K_CAT    = 5'd23;
  localparam logic [4:0] K_COMMA  = 5'd24;
  localparam logic [4:0] K_LPAREN = 5'd25;
  localparam logic [4:0] K_RPAREN = 5'd26;
  localparam logic [4:0] K_DOT    = 5'd27;
  localparam logic [4:0] K_DCOLON = 5'd28;
  localparam logic [4:0] K_DEF    = 5'd29;
  localparam logic [4:0] K_ERR    = 5'd30;
  localparam logic [4:0] K_DONE   = 5'd31;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  localparam int KW_NUM    = 10;
  localparam int KW_MAXLEN = 9;

  // left-justified keyword text, first character in the top byte
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    {"program", 16'h0},
    {"end", 48'h0},
    {"else", 40'h0},
    {"if", 56'h0},
    {"integer", 16'h0},
    {"real", 40'h0},
    {"character"},
    {"print", 32'h0},
    {"len", 48'h0},
    {"then", 40'h0}
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd7, 4'd3, 4'd4, 4'd2, 4'd7, 4'd4, 4'd9, 4'd5, 4'd3, 4'd4
  };

  typedef struct packed {
    logic [7:0] chr;
    logic       eoi;
    logic       alpha;
    logic       digit;
    logic       space;
    logic       quote;
    logic       nl;
    logic [7:0] lower;
  } item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] line;
    logic [31:0] start;
    logic [7:0]  len;
    logic        last;
  } tok_t;

endpackage

[rtl/source_char_tokenizer_top.sv]
// Top level of the source character tokenizer: front, scanner and result queue.
// Depends on tkz_pkg, tkz_front, tkz_scan and tkz_fifo.
//
//   channel  direction  handshake         payload
//   in_      input      in_push/in_full   in_char_in, in_end_of_input
//   out_     output     out_pop/out_empty token kind, line, start, length, last
//
// One character per cycle while the result queue has room; a character that yields
// two tokens holds the next one back until the second token is written, as set by
// the single write port of the result queue.
// rst_n is synchronous; after reset the line counter is 1 and offsets are 0.
// A full result queue stalls the scanner, and a full input queue raises in_full.
module source_char_tokenizer_top #(
  parameter int KEYWORD_CHARS = 10,
  parameter int LENGTH_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_token_kind,
  output logic [23:0] out_line_number,
  output logic [31:0] out_lexeme_start,
  output logic [7:0]  out_lexeme_length,
  output logic        out_last_of_run
);
  import tkz_pkg::*;

  item_t item;
  logic  item_v;
  logic  take;
  logic  oq_wr;
  tok_t  oq_data;
  logic  oq_full;
  tok_t  head;

  tkz_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .char_in     (in_char_in),
    .end_of_input(in_end_of_input),
    .full        (in_full),
    .item        (item),
    .item_v      (item_v),
    .take        (take)
  );

  tkz_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .item_v (item_v),
    .take   (take),
    .oq_wr  (oq_wr),
    .oq_data(oq_data),
    .oq_full(oq_full)
  );

  tkz_fifo #(
    .WIDTH($bits(tok_t)),
    .DEPTH(4)
  ) u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (oq_wr),
    .wr_data(oq_data),
    .rd     (out_pop),
    .rd_data(head),
    .full   (oq_full),
    .empty  (out_empty)
  );

  assign out_token_kind    = head.kind;
  assign out_line_number   = head.line;
  assign out_lexeme_start  = head.start;
  assign out_lexeme_length = head.len;
  assign out_last_of_run   = head.last;

endmodule

[rtl/tkz_fifo.sv]
// Small register queue with first-word-fall-through read.
// Used between the front and the scanner and in front of the result ports.
// No dependencies.
module tkz_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

[rtl/tkz_front.sv]
// Front end: classifies each incoming character and queues it for the scanner.
// Depends on tkz_pkg and tkz_fifo.
module tkz_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    char_in,
  input  logic          end_of_input,
  output logic          full,
  output tkz_pkg::item_t item,
  output logic          item_v,
  input  logic          take
);
  import tkz_pkg::*;

  item_t cls;
  logic  empty;
  logic  upper;

  assign upper = (char_in >= 8'h41) && (char_in <= 8'h5a);

  always_comb begin
    cls.chr   = char_in;
    cls.eoi   = end_of_input;
    cls.alpha = upper || ((char_in >= 8'h61) && (char_in <= 8'h7a));
    cls.digit = (char_in >= 8'h30) && (char_in <= 8'h39);
    cls.space = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0d));
    cls.quote = (char_in == CH_DQUOTE) || (char_in == CH_SQUOTE);
    cls.nl    = (char_in == CH_NL);
    cls.lower = upper ? char_in + 8'd32 : char_in;
  end

  tkz_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (push),
    .wr_data(cls),
    .rd     (take),
    .rd_data(item),
    .full   (full),
    .empty  (empty)
  );

  assign item_v = !empty;

endmodule

[rtl/tkz_scan.sv]
// Back end: scanner state machine that turns classified characters into tokens.
// Depends on tkz_pkg; feeds the result queue one token per cycle while it is not full.
module tkz_scan #(
  parameter int KEYWORD_CHARS = 10,
  parameter int LENGTH_BITS   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tkz_pkg::item_t item,
  input  logic           item_v,
  output logic           take,
  output logic           oq_wr,
  output tkz_pkg::tok_t  oq_data,
  input  logic           oq_full
);
  import tkz_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int IW = $clog2(KEYWORD_CHARS);

  scan_mode_t      mode_r, mode_nxt;
  logic [23:0]     line_r, line_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [31:0]     tstart_r, tstart_nxt;
  logic [LB-1:0]   tlen_r, tlen_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic            oq_r, oq_nxt;
  logic [7:0]      kbuf_r [KEYWORD_CHARS];
  logic            kb_we;
  logic [IW-1:0]   kb_idx;
  logic            hold_v_r, hold_v_nxt;
  tok_t            hold_tok_r;

  logic [LB-1:0]   glen;
  logic [4:0]      idk;
  logic [4:0]      alone_k;
  logic [4:0]      pair_k;
  logic            pair_v;
  logic            b_v;
  logic [4:0]      b_k;
  logic            pre_v;
  logic [4:0]      pre_k;
  logic [LB-1:0]   pre_l;
  logic            do_begin;
  logic            sec_done;
  logic            first_v, two;
  tok_t            t0, t1, tb, td, tp;
  logic [7:0]      c;
  logic            room;
  logic            kw_ok;

  assign c    = item.chr;
  assign glen = (tlen_r == '1) ? tlen_r : tlen_r + LB'(1);

  always_comb begin
    idk = K_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      kw_ok = (int'(tlen_r) == int'(KW_LEN[k]));
      for (int i = 0; i < KW_MAXLEN; i++) begin
        if ((i < int'(KW_LEN[k])) &&
            (kbuf_r[i] != KW_TEXT[k][8*(KW_MAXLEN-i)-1 -: 8])) begin
          kw_ok = 1'b0;
        end
      end
      if (kw_ok) begin
        idk = 5'(k);
      end
    end
  end

  always_comb begin
    case (pend_r)
      CH_STAR:  alone_k = K_MULT;
      CH_SLASH: alone_k = K_DIV;
      CH_EQ:    alone_k = K_ASSOP;
      CH_DOT:   alone_k = K_DOT;
      default:  alone_k = K_ERR;
    endcase
    pair_v = 1'b1;
    case (pend_r)
      CH_STAR:  pair_k = K_POW;
      CH_SLASH: pair_k = K_CAT;
      CH_EQ:    pair_k = K_EQ;
      CH_COLON: pair_k = K_DCOLON;
      default: begin
        pair_k = K_ERR;
        pair_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    b_v = 1'b0;
    b_k = K_ERR;
    if (!item.space && !item.alpha && !item.digit && !item.quote) begin
      b_v = 1'b1;
      case (c)
        CH_PLUS:   b_k = K_PLUS;
        CH_MINUS:  b_k = K_MINUS;
        CH_LT:     b_k = K_LTHAN;
        CH_GT:     b_k = K_GTHAN;
        CH_COMMA:  b_k = K_COMMA;
        CH_LPAREN: b_k = K_LPAREN;
        CH_RPAREN: b_k = K_RPAREN;
        CH_BANG, CH_STAR, CH_SLASH, CH_EQ, CH_COLON, CH_DOT: b_v = 1'b0;
        default:   b_k = K_ERR;
      endcase
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    pend_nxt   = pend_r;
    oq_nxt     = oq_r;
    kb_we      = 1'b0;
    kb_idx     = tlen_r[IW-1:0];
    pre_v      = 1'b0;
    pre_k      = K_ERR;
    pre_l      = tlen_r;
    do_begin   = 1'b0;
    sec_done   = 1'b0;
    if (item.eoi) begin
      case (mode_r)
        M_IDENT: begin
          pre_v = 1'b1;
          pre_k = idk;
        end
        M_INT, M_INTDOT: begin
          pre_v = 1'b1;
          pre_k = K_ICONST;
        end
        M_REAL: begin
          pre_v = 1'b1;
          pre_k = K_RCONST;
        end
        M_STRING: begin
          pre_v = 1'b1;
          pre_k = K_ERR;
        end
        M_OPWAIT: begin
          pre_v = 1'b1;
          pre_k = alone_k;
          pre_l = LB'(1);
        end
        default: ;
      endcase
      mode_nxt = M_START;
      sec_done = 1'b1;
    end else begin
      pos_nxt = pos_r + 32'd1;
      case (mode_r)
        M_START: do_begin = 1'b1;
        M_IDENT: begin
          if (item.alpha || item.digit || (c == CH_USCORE)) begin
            kb_we    = (int'(tlen_r) < KEYWORD_CHARS);
            tlen_nxt = glen;
          end else begin
            pre_v    = 1'b1;
            pre_k    = idk;
            do_begin = 1'b1;
          end
        end
        M_INT: begin
          if (item.digit) begin
            tlen_nxt = glen;
          end else if (c == CH_DOT) begin
            tlen_nxt = glen;
            mode_nxt = M_INTDOT;
          end else begin
            pre_v    = 1'b1;
            pre_k    = K_ICONST;
            do_begin = 1'b1;
          end
        end
        M_INTDOT: begin
          if (item.digit) begin
            tlen_nxt = glen;
            mode_nxt = M_REAL;
          end else begin
            pre_v    = 1'b1;
            pre_k    = K_ICONST;
            do_begin = 1'b1;
          end
        end
        M_REAL: begin
          if (item.digit) begin
            tlen_nxt = glen;
          end else if (item.alpha || (c == CH_DOT)) begin
            tlen_nxt = glen;
            pre_v    = 1'b1;
            pre_k    = K_ERR;
            pre_l    = glen;
            mode_nxt = M_START;
          end else begin
            pre_v    = 1'b1;
            pre_k    = K_RCONST;
            do_begin = 1'b1;
          end
        end
        M_STRING: begin
          if (item.quote) begin
            tlen_nxt = glen;
            pre_v    = 1'b1;
            pre_k    = ((c == CH_SQUOTE) == oq_r) ? K_SCONST : K_ERR;
            pre_l    = glen;
            mode_nxt = M_START;
          end else if (item.nl) begin
            pre_v    = 1'b1;
            pre_k    = K_ERR;
            mode_nxt = M_START;
          end else begin
            tlen_nxt = glen;
          end
        end
        M_COMMENT: begin
          if (item.nl) begin
            do_begin = 1'b1;
          end
        end
        M_OPWAIT: begin
          if ((pend_r == CH_DOT) && item.digit) begin
            mode_nxt = M_REAL;
            tlen_nxt = LB'(2);
          end else if (pair_v && (c == pend_r)) begin
            pre_v    = 1'b1;
            pre_k    = pair_k;
            pre_l    = LB'(2);
            mode_nxt = M_START;
          end else begin
            pre_v    = 1'b1;
            pre_k    = ((pend_r == CH_STAR) && (item.alpha || (c == CH_COMMA))) ?
                       K_DEF : alone_k;
            pre_l    = LB'(1);
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
    end
    if (do_begin) begin
      mode_nxt = M_START;
      if (item.space) begin
        if (item.nl) begin
          line_nxt = line_r + 24'd1;
        end
      end else begin
        tstart_nxt = pos_r;
        tlen_nxt   = LB'(1);
        if (item.alpha) begin
          mode_nxt = M_IDENT;
          kb_we    = 1'b1;
          kb_idx   = '0;
        end else if (item.digit) begin
          mode_nxt = M_INT;
        end else if (item.quote) begin
          mode_nxt = M_STRING;
          oq_nxt   = (c == CH_SQUOTE);
        end else if (c == CH_BANG) begin
          mode_nxt = M_COMMENT;
        end else if ((c == CH_STAR) || (c == CH_SLASH) || (c == CH_EQ) ||
                     (c == CH_COLON) || (c == CH_DOT)) begin
          mode_nxt = M_OPWAIT;
          pend_nxt = c;
        end
      end
    end
  end

  always_comb begin
    tp.kind  = pre_k;
    tp.line  = line_r;
    tp.start = tstart_r;
    tp.len   = 8'(pre_l);
    tp.last  = 1'b1;
    tb.kind  = b_k;
    tb.line  = line_r;
    tb.start = pos_r;
    tb.len   = 8'd1;
    tb.last  = 1'b1;
    td.kind  = K_DONE;
    td.line  = line_r;
    td.start = pos_r;
    td.len   = 8'd0;
    td.last  = 1'b1;
    first_v  = pre_v || (do_begin && b_v) || sec_done;
    two      = pre_v && ((do_begin && b_v) || sec_done);
    t1       = sec_done ? td : tb;
    t0       = pre_v ? tp : t1;
    t0.last  = !two;
  end

  assign room       = !oq_full;
  assign take       = item_v && !hold_v_r && room;
  assign oq_wr      = hold_v_r ? room : (take && first_v);
  assign oq_data    = hold_v_r ? hold_tok_r : t0;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (hold_v_r && room) begin
      hold_v_nxt = 1'b0;
    end else if (take && two) begin
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      line_r   <= 24'd1;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      pend_r   <= '0;
      oq_r     <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      if (take) begin
        mode_r   <= mode_nxt;
        line_r   <= line_nxt;
        pos_r    <= pos_nxt;
        tstart_r <= tstart_nxt;
        tlen_r   <= tlen_nxt;
        pend_r   <= pend_nxt;
        oq_r     <= oq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && kb_we) begin
      kbuf_r[kb_idx] <= item.lower;
    end
    if (take && two) begin
      hold_tok_r <= t1;
    end
  end

  a_no_take_while_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> !take) else $error("item taken while second token held");

  a_two_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    take && two |=> hold_v_r) else $error("second token not held");

  a_line_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(line_r) && $stable(pos_r)) else $error("counters moved without item");

  a_pend_op: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_OPWAIT |-> (pend_r == CH_STAR) || (pend_r == CH_SLASH) ||
    (pend_r == CH_EQ) || (pend_r == CH_COLON) || (pend_r == CH_DOT))
    else $error("bad held operator");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> hold_tok_r.last) else $error("held token not marked last");

endmodule
